FILE: design/token_window_job_scheduler_top_assert.svh
// Assertion macros used by the checker file twjs_checker.sv.
`ifndef TOKEN_WINDOW_JOB_SCHEDULER_TOP_ASSERT_SVH
`define TOKEN_WINDOW_JOB_SCHEDULER_TOP_ASSERT_SVH
`define TWJS_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define TWJS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: design/twjs_pkg.sv
package twjs_pkg;
	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_TICK = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_ADDED = 3'd0,
		EV_RUN = 3'd1,
		EV_FINISHED = 3'd2,
		EV_DISCARDED = 3'd3,
		EV_REMOVED = 3'd4,
		EV_NO_TICKET = 3'd5,
		EV_FULL = 3'd6,
		EV_TICK_DONE = 3'd7
	} ev_t;

	localparam logic [31:0] END_UNLIMITED = 32'hffff_ffff;
	localparam logic [8:0] TOKENS_MAX = 9'h1ff;
	localparam logic [15:0] WAIT_MAX = 16'hffff;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] weight;
		logic [15:0] delay_ms;
		logic [15:0] runtime_ms;
		logic unlimited;
		logic can_discard;
		logic [31:0] job_ticket;
		logic done_req;
		logic [31:0] now_ms;
		logic [15:0] frame_ms;
	} item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [31:0] out_ticket;
		logic [15:0] run_time_ms;
		logic first_run;
		logic last;
	} res_t;
endpackage

FILE: design/twjs_front.sv
module twjs_front #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input twjs_pkg::item_t in_item,
	output logic q_valid,
	input logic q_ready,
	output twjs_pkg::item_t q_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	twjs_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

FILE: design/twjs_back.sv
module twjs_back #(
	parameter int SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] threshold,
	input logic q_valid,
	output logic q_ready,
	input twjs_pkg::item_t q_item,
	output logic out_valid,
	input logic out_ready,
	output twjs_pkg::res_t out_res
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	twjs_pkg::item_t it_q;
	logic [SW-1:0] idx_q;
	logic [SLOTS-1:0] valid_q;
	logic [31:0] ticket_ctr_q;
	logic [31:0] tk_q [SLOTS];
	logic [3:0] wt_q [SLOTS];
	logic [8:0] tok_q [SLOTS];
	logic [31:0] st_q [SLOTS];
	logic [31:0] en_q [SLOTS];
	logic [15:0] wait_q [SLOTS];
	logic [1:0] fl_q [SLOTS];
	logic out_v_q;
	twjs_pkg::res_t out_q;

	logic [SW-1:0] free_idx, hit_idx;
	logic free_any, hit_any;
	logic [31:0] now;
	logic in_win, expired, run_now;
	logic [16:0] rt_sum;
	logic [15:0] rt_sat;
	logic [9:0] tk_sum;
	logic last_slot, out_free, out_load;

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		hit_idx = '0;
		hit_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SW'(i);
				free_any = 1'b1;
			end
			if (valid_q[i] && tk_q[i] == q_item.job_ticket) begin
				hit_idx = SW'(i);
				hit_any = 1'b1;
			end
		end
	end

	assign now = it_q.now_ms;
	assign in_win = (st_q[idx_q] <= now) && (now < en_q[idx_q]);
	assign expired = (now >= en_q[idx_q]);
	assign run_now = in_win && (tok_q[idx_q] >= {1'b0, threshold});
	assign rt_sum = {1'b0, wait_q[idx_q]} + {1'b0, it_q.frame_ms};
	assign rt_sat = rt_sum[16] ? twjs_pkg::WAIT_MAX : rt_sum[15:0];
	assign tk_sum = {1'b0, tok_q[idx_q]} + {6'd0, wt_q[idx_q]};
	assign last_slot = (idx_q == SW'(SLOTS - 1));
	assign out_free = !out_v_q || out_ready;
	assign q_ready = (state_q == ST_IDLE) && out_free;
	assign out_valid = out_v_q;
	assign out_res = out_q;
	assign out_load = out_free && (
		(state_q == ST_IDLE && q_valid && q_item.cmd != twjs_pkg::CMD_TICK &&
			(q_item.cmd != twjs_pkg::CMD_REPORT || !hit_any || q_item.done_req)) ||
		(state_q == ST_SCAN && valid_q[idx_q] &&
			(run_now || (expired && fl_q[idx_q][1]))) ||
		(state_q == ST_DONE));

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && out_free) begin
			it_q <= q_item;
			if (q_item.cmd == twjs_pkg::CMD_ADD && free_any) begin
				tk_q[free_idx] <= ticket_ctr_q + 32'd1;
				wt_q[free_idx] <= q_item.weight;
				tok_q[free_idx] <= {5'd0, q_item.weight};
				st_q[free_idx] <= q_item.now_ms + {16'd0, q_item.delay_ms};
				en_q[free_idx] <= q_item.unlimited ? twjs_pkg::END_UNLIMITED :
					q_item.now_ms + {16'd0, q_item.delay_ms} + {16'd0, q_item.runtime_ms};
				wait_q[free_idx] <= '0;
				fl_q[free_idx] <= {q_item.can_discard, 1'b0};
			end
		end else if (state_q == ST_SCAN && valid_q[idx_q] && in_win) begin
			if (run_now) begin
				if (out_free) begin
					fl_q[idx_q][0] <= 1'b1;
					tok_q[idx_q] <= {5'd0, wt_q[idx_q]};
					wait_q[idx_q] <= '0;
				end
			end else begin
				tok_q[idx_q] <= tk_sum[9] ? twjs_pkg::TOKENS_MAX : tk_sum[8:0];
				wait_q[idx_q] <= rt_sat;
			end
		end
		if (state_q == ST_IDLE && q_valid && out_free) begin
			out_q.run_time_ms <= '0;
			out_q.first_run <= 1'b0;
			out_q.last <= 1'b1;
			unique case (q_item.cmd)
				twjs_pkg::CMD_ADD: begin
					out_q.event_res <= free_any ? twjs_pkg::EV_ADDED : twjs_pkg::EV_FULL;
					out_q.out_ticket <= free_any ? ticket_ctr_q + 32'd1 : '0;
				end
				twjs_pkg::CMD_TICK: begin
					out_q.event_res <= twjs_pkg::EV_TICK_DONE;
					out_q.out_ticket <= '0;
				end
				twjs_pkg::CMD_REMOVE: begin
					out_q.event_res <= hit_any ? twjs_pkg::EV_REMOVED :
						twjs_pkg::EV_NO_TICKET;
					out_q.out_ticket <= q_item.job_ticket;
				end
				default: begin
					out_q.event_res <= hit_any ? twjs_pkg::EV_FINISHED :
						twjs_pkg::EV_NO_TICKET;
					out_q.out_ticket <= q_item.job_ticket;
				end
			endcase
		end else if (state_q == ST_SCAN && out_free && valid_q[idx_q]) begin
			out_q.last <= 1'b0;
			out_q.out_ticket <= tk_q[idx_q];
			if (run_now) begin
				out_q.event_res <= twjs_pkg::EV_RUN;
				out_q.run_time_ms <= rt_sat;
				out_q.first_run <= !fl_q[idx_q][0];
			end else begin
				out_q.event_res <= twjs_pkg::EV_DISCARDED;
				out_q.run_time_ms <= '0;
				out_q.first_run <= 1'b0;
			end
		end else if (state_q == ST_DONE && out_free) begin
			out_q.event_res <= twjs_pkg::EV_TICK_DONE;
			out_q.out_ticket <= '0;
			out_q.run_time_ms <= '0;
			out_q.first_run <= 1'b0;
			out_q.last <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			ticket_ctr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && out_free) begin
						idx_q <= '0;
						case (q_item.cmd)
							twjs_pkg::CMD_ADD: begin
								if (free_any) begin
									valid_q[free_idx] <= 1'b1;
									ticket_ctr_q <= ticket_ctr_q + 32'd1;
								end
							end
							twjs_pkg::CMD_TICK: begin
								state_q <= ST_SCAN;
							end
							twjs_pkg::CMD_REMOVE: begin
								if (hit_any) begin
									valid_q[hit_idx] <= 1'b0;
								end
							end
							default: begin
								if (hit_any && q_item.done_req) begin
									valid_q[hit_idx] <= 1'b0;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (valid_q[idx_q] && (run_now || (expired && fl_q[idx_q][1]))) begin
						if (out_free) begin
							if (!run_now) begin
								valid_q[idx_q] <= 1'b0;
							end
							idx_q <= idx_q + 1'b1;
							if (last_slot) begin
								state_q <= ST_DONE;
							end
						end
					end else begin
						if (valid_q[idx_q] && !in_win && expired) begin
							valid_q[idx_q] <= 1'b0;
						end
						idx_q <= idx_q + 1'b1;
						if (last_slot) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: design/token_window_job_scheduler_top.sv
// Add, remove and report items pass through the queue, then the registered result.
// A tick item walks every slot, one slot per cycle while the output is not stalled,
// then emits its closing event.
// A two-entry queue decouples input acceptance from the slot engine.
// arst_n clears all slots, the ticket counter and sets the threshold to 4.
module token_window_job_scheduler_top #(
	parameter int SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [3:0] weight,
	input logic [15:0] delay_ms,
	input logic [15:0] runtime_ms,
	input logic unlimited,
	input logic can_discard,
	input logic [31:0] job_ticket,
	input logic done_req,
	input logic [31:0] now_ms,
	input logic [15:0] frame_ms,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] event_res,
	output logic [31:0] out_ticket,
	output logic [15:0] run_time_ms,
	output logic first_run,
	output logic last
);
	logic [7:0] threshold_q;
	twjs_pkg::item_t in_item, q_item;
	twjs_pkg::res_t res;
	logic q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 8'd4;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign in_item = '{cmd: cmd, weight: weight, delay_ms: delay_ms,
		runtime_ms: runtime_ms, unlimited: unlimited, can_discard: can_discard,
		job_ticket: job_ticket, done_req: done_req, now_ms: now_ms,
		frame_ms: frame_ms};

	twjs_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	twjs_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .threshold(threshold_q), .q_valid(q_valid),
		.q_ready(q_ready), .q_item(q_item), .out_valid(out_valid),
		.out_ready(out_ready), .out_res(res)
	);

	assign event_res = res.event_res;
	assign out_ticket = res.out_ticket;
	assign run_time_ms = res.run_time_ms;
	assign first_run = res.first_run;
	assign last = res.last;
endmodule

FILE: design/twjs_checker.sv
`include "token_window_job_scheduler_top_assert.svh"
module twjs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] event_res,
	input logic [31:0] out_ticket,
	input logic [15:0] run_time_ms,
	input logic first_run,
	input logic last
);
	`TWJS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ticket))
	`TWJS_ASSERT_IMPL(a_tick_last, out_valid && event_res == twjs_pkg::EV_TICK_DONE, last)
	`TWJS_ASSERT_IMPL(a_run_not_last, out_valid && event_res == twjs_pkg::EV_RUN, !last)
	`TWJS_ASSERT_IMPL(a_first_only_run, out_valid && first_run, event_res == twjs_pkg::EV_RUN)
	`TWJS_ASSERT_IMPL(a_time_only_run, out_valid && event_res != twjs_pkg::EV_RUN, run_time_ms == '0)
endmodule

bind token_window_job_scheduler_top twjs_checker u_twjs_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.event_res(event_res), .out_ticket(out_ticket), .run_time_ms(run_time_ms),
	.first_run(first_run), .last(last)
);

FILE: sim/token_window_job_scheduler_top_tb.sv
`timescale 1ns / 100ps

module token_window_job_scheduler_top_tb;
	localparam int NSLOTS = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	twjs_pkg::item_t cur = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] event_res;
	logic [31:0] out_ticket;
	logic [15:0] run_time_ms;
	logic first_run;
	logic last;

	token_window_job_scheduler_top #(.SLOTS(NSLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cur.cmd), .weight(cur.weight), .delay_ms(cur.delay_ms),
		.runtime_ms(cur.runtime_ms), .unlimited(cur.unlimited),
		.can_discard(cur.can_discard), .job_ticket(cur.job_ticket),
		.done_req(cur.done_req), .now_ms(cur.now_ms), .frame_ms(cur.frame_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_res(event_res), .out_ticket(out_ticket),
		.run_time_ms(run_time_ms), .first_run(first_run), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scheduler image used to work out the expected events.
	logic [7:0] threshold = 8'd4;
	logic job_live [NSLOTS];
	logic [31:0] job_ticket_q [NSLOTS];
	logic [3:0] job_weight [NSLOTS];
	logic [8:0] job_tokens [NSLOTS];
	logic [31:0] job_start [NSLOTS];
	logic [31:0] job_end [NSLOTS];
	logic [15:0] job_waited [NSLOTS];
	logic job_started [NSLOTS];
	logic job_discard [NSLOTS];
	logic [31:0] tickets_issued = '0;

	twjs_pkg::item_t pending_items [$];
	twjs_pkg::res_t expected_events [$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int adds_made = 0;
	logic [31:0] clock_ms = 32'd1000;

	initial begin
		for (int i = 0; i < NSLOTS; i++)
			job_live[i] = 1'b0;
	end

	function automatic void queue_item(twjs_pkg::item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic void push_event(twjs_pkg::ev_t ev, logic [31:0] t, logic [15:0] rt,
		logic f);
		twjs_pkg::res_t r;
		r.event_res = ev;
		r.out_ticket = t;
		r.run_time_ms = rt;
		r.first_run = f;
		r.last = 1'b0;
		expected_events = {expected_events, r};
	endfunction

	function automatic void schedule_item(twjs_pkg::item_t it);
		int before_n;
		int slot;
		logic [9:0] tk;
		logic [16:0] w;
		logic [31:0] st;
		before_n = expected_events.size();
		slot = -1;
		case (it.cmd)
			twjs_pkg::CMD_ADD: begin
				for (int i = 0; i < NSLOTS; i++)
					if (!job_live[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					push_event(twjs_pkg::EV_FULL, '0, '0, 1'b0);
				end else begin
					st = it.now_ms + {16'd0, it.delay_ms};
					tickets_issued = tickets_issued + 32'd1;
					job_live[slot] = 1'b1;
					job_ticket_q[slot] = tickets_issued;
					job_weight[slot] = it.weight;
					job_tokens[slot] = {5'd0, it.weight};
					job_start[slot] = st;
					job_end[slot] = it.unlimited ? twjs_pkg::END_UNLIMITED :
						st + {16'd0, it.runtime_ms};
					job_waited[slot] = '0;
					job_started[slot] = 1'b0;
					job_discard[slot] = it.can_discard;
					push_event(twjs_pkg::EV_ADDED, tickets_issued, '0, 1'b0);
				end
			end
			twjs_pkg::CMD_TICK: begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (!job_live[i])
						continue;
					if (job_start[i] <= it.now_ms && it.now_ms < job_end[i]) begin
						w = {1'b0, job_waited[i]} + {1'b0, it.frame_ms};
						if (w > {1'b0, twjs_pkg::WAIT_MAX})
							w = {1'b0, twjs_pkg::WAIT_MAX};
						if (job_tokens[i] >= {1'b0, threshold}) begin
							push_event(twjs_pkg::EV_RUN, job_ticket_q[i], w[15:0],
								!job_started[i]);
							job_started[i] = 1'b1;
							job_tokens[i] = {5'd0, job_weight[i]};
							job_waited[i] = '0;
						end else begin
							tk = {1'b0, job_tokens[i]} + {6'd0, job_weight[i]};
							if (tk > {1'b0, twjs_pkg::TOKENS_MAX})
								tk = {1'b0, twjs_pkg::TOKENS_MAX};
							job_tokens[i] = tk[8:0];
							job_waited[i] = w[15:0];
						end
					end else if (it.now_ms >= job_end[i]) begin
						job_live[i] = 1'b0;
						if (job_discard[i])
							push_event(twjs_pkg::EV_DISCARDED, job_ticket_q[i], '0, 1'b0);
					end
				end
				push_event(twjs_pkg::EV_TICK_DONE, '0, '0, 1'b0);
			end
			default: begin
				for (int i = 0; i < NSLOTS; i++)
					if (job_live[i] && job_ticket_q[i] == it.job_ticket && slot < 0)
						slot = i;
				if (slot < 0) begin
					push_event(twjs_pkg::EV_NO_TICKET, it.job_ticket, '0, 1'b0);
				end else if (it.cmd == twjs_pkg::CMD_REMOVE) begin
					job_live[slot] = 1'b0;
					push_event(twjs_pkg::EV_REMOVED, it.job_ticket, '0, 1'b0);
				end else if (it.done_req) begin
					job_live[slot] = 1'b0;
					push_event(twjs_pkg::EV_FINISHED, it.job_ticket, '0, 1'b0);
				end
			end
		endcase
		if (expected_events.size() > before_n)
			expected_events[expected_events.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				schedule_item(cur);
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		twjs_pkg::res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event_res=%0d out_ticket=%0d", event_res, out_ticket);
					errors++;
				end else begin
					e = expected_events.pop_front();
					if (event_res !== e.event_res) begin
						$error("event_res expected %0d actual %0d", e.event_res, event_res);
						errors++;
					end
					if (out_ticket !== e.out_ticket) begin
						$error("out_ticket expected %0d actual %0d", e.out_ticket, out_ticket);
						errors++;
					end
					if (run_time_ms !== e.run_time_ms) begin
						$error("run_time_ms expected %0d actual %0d", e.run_time_ms,
							run_time_ms);
						errors++;
					end
					if (first_run !== e.first_run) begin
						$error("first_run expected %0d actual %0d", e.first_run, first_run);
						errors++;
					end
					if (last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, last);
						errors++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				recv_gap = 600;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL token_window_job_scheduler_top");
			$finish;
		end
	end

	function automatic twjs_pkg::item_t random_fields();
		logic [127:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom};
		return rnd[$bits(twjs_pkg::item_t)-1:0];
	endfunction

	function automatic twjs_pkg::item_t job_add(logic [3:0] wt, logic [15:0] dly,
		logic [15:0] rt, logic unl, logic disc, logic [31:0] now);
		twjs_pkg::item_t it;
		it = random_fields();
		it.cmd = twjs_pkg::CMD_ADD;
		it.weight = wt;
		it.delay_ms = dly;
		it.runtime_ms = rt;
		it.unlimited = unl;
		it.can_discard = disc;
		it.now_ms = now;
		adds_made++;
		return it;
	endfunction

	function automatic twjs_pkg::item_t job_cmd(twjs_pkg::cmd_t c, logic [31:0] t, logic d,
		logic [31:0] now, logic [15:0] frame);
		twjs_pkg::item_t it;
		it = random_fields();
		it.cmd = c;
		it.job_ticket = t;
		it.done_req = d;
		it.now_ms = now;
		it.frame_ms = frame;
		return it;
	endfunction

	function automatic twjs_pkg::item_t random_item();
		twjs_pkg::item_t it;
		int pick;
		logic [15:0] frame;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it = job_add(4'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 60)), ($urandom_range(0, 9) == 0) ?
				16'($urandom) : 16'($urandom_range(0, 400)),
				$urandom_range(0, 7) == 0, 1'($urandom), clock_ms);
		end else if (pick < 65) begin
			frame = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
				16'($urandom_range(1, 80));
			clock_ms = clock_ms + {16'd0, frame};
			it = job_cmd(twjs_pkg::CMD_TICK, $urandom, 1'($urandom), clock_ms, frame);
		end else if (pick < 95) begin
			it = job_cmd((pick < 85) ? twjs_pkg::CMD_REPORT : twjs_pkg::CMD_REMOVE,
				($urandom_range(0, 9) == 0) ? 32'($urandom) :
				32'(adds_made - $urandom_range(0, 12)), 1'($urandom), $urandom,
				16'($urandom));
		end else begin
			it = random_fields();
			if (it.cmd == twjs_pkg::CMD_ADD)
				adds_made++;
		end
		return it;
	endfunction

	task automatic write_threshold(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_events.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		logic [7:0] settings [5];
		settings = '{8'd0, 8'd255, 8'd1, 8'd4, 8'd0};
		settings[4] = 8'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_item(job_add(4'd15, 16'd0, 16'd100, 1'b0, 1'b1, 32'd1000));
		queue_item(job_add(4'd0, 16'hffff, 16'hffff, 1'b0, 1'b0, 32'd1000));
		queue_item(job_add(4'd1, 16'd0, 16'd0, 1'b1, 1'b1, 32'hffff_fff0));
		queue_item(job_add(4'd8, 16'd5, 16'd0, 1'b0, 1'b1, 32'd1000));
		queue_item(job_add(4'd2, 16'd0, 16'd500, 1'b0, 1'b0, 32'd0));
		queue_item(job_cmd(twjs_pkg::CMD_TICK, 32'd0, 1'b0, 32'd1000, 16'hffff));
		queue_item(job_cmd(twjs_pkg::CMD_TICK, 32'd0, 1'b0, 32'd1050, 16'd50));
		queue_item(job_cmd(twjs_pkg::CMD_REPORT, 32'd1, 1'b0, 32'd0, 16'd0));
		queue_item(job_cmd(twjs_pkg::CMD_REPORT, 32'd1, 1'b1, 32'd0, 16'd0));
		queue_item(job_cmd(twjs_pkg::CMD_REMOVE, 32'd2, 1'b0, 32'd0, 16'd0));
		queue_item(job_cmd(twjs_pkg::CMD_REMOVE, 32'hffff_ffff, 1'b0, 32'd0, 16'd0));
		queue_item(job_cmd(twjs_pkg::CMD_REPORT, 32'd0, 1'b1, 32'd0, 16'd0));
		for (int i = 0; i < 13; i++)
			queue_item(job_add(4'($urandom), 16'd0, 16'd1000, 1'b0, 1'b1, 32'd1100));
		queue_item(job_cmd(twjs_pkg::CMD_TICK, 32'd0, 1'b0, 32'hffff_ffff, 16'd10));
		drain();

		for (int p = 0; p < 5; p++) begin
			write_threshold(settings[p]);
			if (p == 4)
				idle_on = 1'b0;
			for (int i = 0; i < 47; i++)
				queue_item(random_item());
			if (p == 1) begin
				@(posedge clk);
				hold_request = 1'b1;
			end
			drain();
		end

		if (errors == 0)
			$display("PASS token_window_job_scheduler_top");
		else
			$display("FAIL token_window_job_scheduler_top");
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/twjs_pkg.sv
design/twjs_front.sv
design/twjs_back.sv
design/token_window_job_scheduler_top.sv
design/twjs_checker.sv
sim/token_window_job_scheduler_top_tb.sv
